@@ rtl/gaed_pkg.sv @@
`timescale 1ns / 1ps
// Package for the gray plus alpha error-diffusion dither.
// Holds register index codes, the per-channel result type and the channel
// arithmetic. Depends on nothing.
package gaed_pkg;

	localparam int LEVEL_W = 8;
	localparam int SUM_W   = 16;
	localparam int ERR_W   = 13;
	localparam int CFG_W   = 16;
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 16;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                    hi;     // output bit of the channel
		logic signed [ERR_W-1:0] err;    // quantization error
		logic signed [SUM_W-1:0] below;  // finished sum, one column to the left
		logic signed [SUM_W-1:0] pend;   // new partial sum under this pixel
	} chan_res_t;

	function automatic logic signed [SUM_W-1:0] sat16(input logic signed [19:0] v);
		logic signed [SUM_W-1:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SUM_W-1:0];
		end
		return r;
	endfunction

	// One channel of Floyd-Steinberg with weights 7,3,5,1 over 16.
	function automatic chan_res_t dither_ch(
		input logic [LEVEL_W-1:0]    level,
		input logic signed [SUM_W-1:0] above,
		input logic signed [SUM_W-1:0] left,
		input logic signed [SUM_W-1:0] pend0,
		input logic signed [SUM_W-1:0] pend1
	);
		logic signed [19:0]       sum7;
		logic signed [SUM_W-1:0]  s;
		logic signed [16:0]       sb;
		logic signed [ERR_W-1:0]  q;
		logic signed [ERR_W-1:0]  lvl;
		logic signed [ERR_W-1:0]  e;
		logic signed [17:0]       wsum;
		logic signed [17:0]       psum;
		chan_res_t                r;
		sum7 = 20'(above) + 20'(left) * 20'sd7;
		s    = sat16(sum7);
		// round toward zero: bias negative sums before the shift
		sb   = 17'(s) + (s[SUM_W-1] ? 17'sd15 : 17'sd0);
		q    = ERR_W'(sb >>> 4);
		lvl  = $signed({5'b00000, level}) + q;
		r.hi = (lvl > 13'sd127);
		e    = lvl - (r.hi ? 13'sd255 : 13'sd0);
		r.err = e;
		wsum = 18'(pend0) + 18'(e) * 18'sd3;
		psum = 18'(pend1) + 18'(e) * 18'sd5;
		r.below = sat16(20'(wsum));
		r.pend  = sat16(20'(psum));
		return r;
	endfunction

endpackage

@@ rtl/gray_alpha_error_diffusion_dither.sv @@
`timescale 1ns / 1ps
// Top level of the gray plus alpha Floyd-Steinberg dither.
// Depends on gaed_pkg for index codes, the channel type and its arithmetic.

// Takes one raster-order pixel per beat and returns one beat per pixel, one
// pixel per clock when both sides keep up; a result passes through the input
// register, then the output register. The rate is set by the line buffer: a
// MAX_WIDTH x 32 bit memory holding the gray and alpha error sums for the
// next row, read once and written at most once per pixel. The sum for the
// last column of a row is held in a register and written while the next
// row's first pixel passes. The line buffer has no reset and no clearing
// pass; the first row discards what it reads. Write image_width and
// image_height only while the block is idle.
module gray_alpha_error_diffusion_dither
	import gaed_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	// pixel input
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // [7:0] gray_level, [15:8] alpha_level
	// dithered output
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [0] gray_bit, [1] alpha_bit, [7:2] zero
	output logic                m_tlast,   // row_end
	output logic                m_tuser    // image_end
);

	localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW = (COLW + 1 > WIDTH_W) ? COLW + 1 : WIDTH_W;
	localparam logic [CMPW-1:0] MAXW = CMPW'(MAX_WIDTH);
	localparam logic [COLW-1:0] LAST_IDX_MAX = COLW'(MAX_WIDTH - 1);

	// configuration
	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;

	// position of the next pixel
	logic [COLW-1:0]     col_q;
	logic [15:0]         row_q;
	logic [COLW-1:0]     last_idx;
	logic [15:0]         last_row_idx;
	logic                last_col;
	logic                last_row;

	// input stage
	logic                s1_valid;
	logic [7:0]          gray_s1;
	logic [7:0]          alpha_s1;
	logic [COLW-1:0]     col_s1;
	logic                first_row_s1;
	logic                last_col_s1;
	logic                last_row_s1;
	logic [31:0]         rdata_s1;
	logic                byp_hit_s1;
	logic [31:0]         byp_data_s1;

	// output stage
	logic                out_valid_q;
	logic                gray_bit_s2;
	logic                alpha_bit_s2;
	logic                row_end_s2;
	logic                image_end_s2;

	// running error state
	logic signed [SUM_W-1:0] g_left_q, g_pend0_q, g_pend1_q;
	logic signed [SUM_W-1:0] a_left_q, a_pend0_q, a_pend1_q;
	logic                tail_valid_q;
	logic [COLW-1:0]     tail_col_q;
	logic [31:0]         tail_data_q;

	// line buffer
	logic [31:0]         lbuf [MAX_WIDTH];
	logic                mem_we;
	logic [COLW-1:0]     mem_waddr;
	logic [31:0]         mem_wdata;

	logic                accept;
	logic                adv;
	logic [31:0]         above_pair;
	logic signed [SUM_W-1:0] g_above, a_above;
	chan_res_t           g_res, a_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_W'(1024);
			image_height_q <= HEIGHT_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the width to 1..MAX_WIDTH and the height to at least 1
	always_comb begin
		if (CMPW'(image_width_q) >= MAXW) begin
			last_idx = LAST_IDX_MAX;
		end else if (image_width_q == '0) begin
			last_idx = '0;
		end else begin
			last_idx = COLW'(CMPW'(image_width_q) - CMPW'(1));
		end
		last_row_idx = (image_height_q == '0) ? '0 : image_height_q - 16'd1;
		last_col = (col_q >= last_idx);
		last_row = (row_q >= last_row_idx);
	end

	assign adv      = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (adv) begin
				s1_valid <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + COLW'(1);
				end
			end
		end
	end

	// capture the beat, its position and a note of any write landing on the
	// address read in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1      <= s_tdata[7:0];
			alpha_s1     <= s_tdata[15:8];
			col_s1       <= col_q;
			first_row_s1 <= (row_q == '0);
			last_col_s1  <= last_col;
			last_row_s1  <= last_row;
			byp_hit_s1   <= mem_we && (mem_waddr == col_q);
			byp_data_s1  <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1 <= lbuf[col_q];
		end
		if (mem_we) begin
			lbuf[mem_waddr] <= mem_wdata;
		end
	end

	// newest copy of the sum above: held tail, then same-cycle write, then memory
	always_comb begin
		if (tail_valid_q && (tail_col_q == col_s1)) begin
			above_pair = tail_data_q;
		end else if (byp_hit_s1) begin
			above_pair = byp_data_s1;
		end else begin
			above_pair = rdata_s1;
		end
		g_above = first_row_s1 ? '0 : $signed(above_pair[15:0]);
		a_above = first_row_s1 ? '0 : $signed(above_pair[31:16]);
		g_res = dither_ch(gray_s1, g_above, g_left_q, g_pend0_q, g_pend1_q);
		a_res = dither_ch(alpha_s1, a_above, a_left_q, a_pend0_q, a_pend1_q);
	end

	// at most one write per pixel: the column to the left, or the held tail on column 0
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = col_s1 - COLW'(1);
		mem_wdata = {a_res.below, g_res.below};
		if (adv) begin
			if (col_s1 != '0) begin
				mem_we = 1'b1;
			end else begin
				mem_we    = tail_valid_q;
				mem_waddr = tail_col_q;
				mem_wdata = tail_data_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_left_q     <= '0;
			g_pend0_q    <= '0;
			g_pend1_q    <= '0;
			a_left_q     <= '0;
			a_pend0_q    <= '0;
			a_pend1_q    <= '0;
			tail_valid_q <= 1'b0;
		end else if (adv) begin
			if (last_col_s1) begin
				// drop errors past the right edge and start the next row clean
				g_left_q     <= '0;
				g_pend0_q    <= '0;
				g_pend1_q    <= '0;
				a_left_q     <= '0;
				a_pend0_q    <= '0;
				a_pend1_q    <= '0;
				tail_valid_q <= 1'b1;
			end else begin
				g_left_q  <= SUM_W'(g_res.err);
				g_pend0_q <= g_res.pend;
				g_pend1_q <= SUM_W'(g_res.err);
				a_left_q  <= SUM_W'(a_res.err);
				a_pend0_q <= a_res.pend;
				a_pend1_q <= SUM_W'(a_res.err);
				if (col_s1 == '0) begin
					tail_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gray_bit_s2  <= g_res.hi && a_res.hi;
			alpha_bit_s2 <= a_res.hi;
			row_end_s2   <= last_col_s1;
			image_end_s2 <= last_col_s1 && last_row_s1;
			if (last_col_s1) begin
				tail_col_q  <= col_s1;
				tail_data_q <= {a_res.pend, g_res.pend};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, alpha_bit_s2, gray_bit_s2};
	assign m_tlast  = row_end_s2;
	assign m_tuser  = image_end_s2;

	// a row always starts with no error carried in from the left
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && (col_s1 == '0) |-> (g_left_q == '0) && (a_left_q == '0))
		else $error("left error not cleared at row start");

	// the held tail is flushed by the first pixel of the next row
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (col_s1 == '0) && tail_valid_q |-> mem_we && (mem_waddr == tail_col_q))
		else $error("tail sum not written at row start");

	// an image end is always also a row end
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("image end without row end");

endmodule
